[sv/pfra_pkg.sv]
// Package for the page frame refcount allocator.
// Holds command and status codes, register indexes, map constants and shared structs.
// No dependencies.
`default_nettype none

package pfra_pkg;

   localparam int ADDR_W     = 26;
   localparam int PAGE_SHIFT = 12;
   localparam int PGNUM_W    = ADDR_W - PAGE_SHIFT;

   localparam logic [1:0] CMD_INIT  = 2'd0;
   localparam logic [1:0] CMD_ALLOC = 2'd1;
   localparam logic [1:0] CMD_FREE  = 2'd2;

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_NO_PAGE   = 3'd1;
   localparam logic [2:0] ST_KERNEL    = 3'd2;
   localparam logic [2:0] ST_RANGE     = 3'd3;
   localparam logic [2:0] ST_TOO_SMALL = 3'd4;

   localparam logic [1:0] CSR_MEMORY_BYTES = 2'd0;
   localparam logic [1:0] CSR_KERNEL_LIMIT = 2'd1;
   localparam logic [1:0] CSR_FREE_LIMIT   = 2'd2;

   localparam logic [31:0] MEM_CAP   = 32'h03C0_0000;
   localparam logic [31:0] PAGE_MASK = 32'hFFFF_F000;
   localparam logic [31:0] MEM_MIN   = 32'h0040_0000;

   localparam logic [7:0] BUF_COUNT      = 8'd100;
   localparam logic [7:0] RESERVED_COUNT = 8'd255;
   localparam logic [7:0] CLAIMED_COUNT  = 8'd1;

   localparam logic [31:0]       RST_MEMORY_BYTES = 32'd62914560;
   localparam logic [ADDR_W-1:0] RST_KERNEL_LIMIT = 26'd1048576;
   localparam logic [31:0]       RST_FREE_LIMIT   = 32'd62914560;

   typedef struct packed {
      logic [31:0]       memory_bytes;
      logic [ADDR_W-1:0] kernel_limit;
      logic [31:0]       free_limit;
   } pfra_cfg_type;

   typedef struct packed {
      logic        valid;
      logic [1:0]  command;
      logic [31:0] address;
   } pfra_req_type;

   typedef struct packed {
      logic              valid;
      logic [ADDR_W-1:0] page_address;
      logic [2:0]        status;
   } pfra_res_type;

endpackage

`default_nettype wire

[sv/pfra_engine.sv]
// Command sequencer and page count map for the page frame refcount allocator.
// Owns the count memory (one read, one write port, registered read); uses pfra_pkg.
`default_nettype none

module pfra_engine
   import pfra_pkg::*;
#(
   parameter int PAGE_COUNT = 16384
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire pfra_cfg_type cfg,
   input  wire pfra_req_type req,
   output logic              ready,
   input  wire logic         out_free,
   output pfra_res_type      res
);

   localparam int PIDX_W = $clog2(PAGE_COUNT);
   localparam int CW     = (PIDX_W > PGNUM_W) ? PIDX_W : PGNUM_W;
   localparam logic [CW-1:0] LAST_PAGE  = CW'(PAGE_COUNT - 1);
   localparam logic [20:0]   PAGE_LIMIT = 21'(PAGE_COUNT);

   localparam logic [2:0] S_IDLE    = 3'd0;
   localparam logic [2:0] S_INIT    = 3'd1;
   localparam logic [2:0] S_SCAN    = 3'd2;
   localparam logic [2:0] S_FREE_WR = 3'd3;
   localparam logic [2:0] S_FIN     = 3'd4;

   logic [7:0] map_mem [PAGE_COUNT];
   logic [7:0] rd_data_ff;

   logic [2:0]          state_ff, state_in;
   logic [PIDX_W-1:0]   idx_ff, idx_in;
   logic [PIDX_W-1:0]   last_ff, last_in;
   logic [PGNUM_W-1:0]  kern_ff, kern_in;
   logic [PGNUM_W-1:0]  buf_ff, buf_in;
   logic [ADDR_W-1:0]   res_addr_ff, res_addr_in;
   logic [2:0]          res_status_ff, res_status_in;

   logic              wr_en;
   logic [PIDX_W-1:0] wr_addr;
   logic [7:0]        wr_data;
   logic [PIDX_W-1:0] rd_addr;

   logic [ADDR_W-1:0]  size_cap;
   logic [ADDR_W-1:0]  size_pg;
   logic [ADDR_W-1:0]  quarter_m1;
   logic [PGNUM_W-1:0] end_pg;
   logic [CW-1:0]      end_cw;
   logic [CW-1:0]      kern_cw;
   logic [CW-1:0]      top_cw;
   logic [20:0]        free_pg;
   logic [CW-1:0]      idx_cw;

   assign size_cap   = (cfg.memory_bytes > MEM_CAP) ? MEM_CAP[ADDR_W-1:0]
                                                    : cfg.memory_bytes[ADDR_W-1:0];
   assign size_pg    = size_cap & PAGE_MASK[ADDR_W-1:0];
   assign quarter_m1 = {2'b00, size_pg[ADDR_W-1:2]} - ADDR_W'(1);
   assign end_pg     = size_pg[ADDR_W-1:PAGE_SHIFT] - PGNUM_W'(1);
   assign end_cw     = CW'(end_pg);
   assign kern_cw    = CW'(cfg.kernel_limit[ADDR_W-1:PAGE_SHIFT]);
   assign top_cw     = (kern_cw > end_cw) ? kern_cw : end_cw;
   assign free_pg    = {1'b0, req.address[31:PAGE_SHIFT]};
   assign idx_cw     = CW'(idx_ff);

   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      last_in       = last_ff;
      kern_in       = kern_ff;
      buf_in        = buf_ff;
      res_addr_in   = res_addr_ff;
      res_status_in = res_status_ff;
      wr_en         = 1'b0;
      wr_addr       = idx_ff;
      wr_data       = 8'd0;
      rd_addr       = idx_ff + PIDX_W'(1);

      case (state_ff)
         S_IDLE: begin
            res_addr_in   = '0;
            res_status_in = ST_OK;
            rd_addr       = '0;
            if (req.valid) begin
               idx_in   = '0;
               state_in = S_FIN;
               case (req.command)
                  CMD_INIT: begin
                     if (size_pg < MEM_MIN[ADDR_W-1:0]) begin
                        res_status_in = ST_TOO_SMALL;
                     end else begin
                        kern_in  = cfg.kernel_limit[ADDR_W-1:PAGE_SHIFT];
                        buf_in   = quarter_m1[ADDR_W-1:PAGE_SHIFT];
                        last_in  = (top_cw > LAST_PAGE) ? PIDX_W'(LAST_PAGE)
                                                        : PIDX_W'(top_cw);
                        state_in = S_INIT;
                     end
                  end
                  CMD_ALLOC: begin
                     state_in = S_SCAN;
                  end
                  CMD_FREE: begin
                     if (req.address < {6'd0, cfg.kernel_limit}) begin
                        res_status_in = ST_KERNEL;
                     end else if (req.address >= cfg.free_limit
                                  || free_pg >= PAGE_LIMIT) begin
                        res_status_in = ST_RANGE;
                     end else begin
                        idx_in   = PIDX_W'(free_pg);
                        rd_addr  = PIDX_W'(free_pg);
                        state_in = S_FREE_WR;
                     end
                  end
                  default: begin
                     state_in = S_FIN;
                  end
               endcase
            end
         end
         S_INIT: begin
            wr_en = 1'b1;
            if (idx_cw <= CW'(kern_ff)) begin
               wr_data = RESERVED_COUNT;
            end else if (idx_cw <= CW'(buf_ff)) begin
               wr_data = BUF_COUNT;
            end else begin
               wr_data = 8'd0;
            end
            idx_in = idx_ff + PIDX_W'(1);
            if (idx_ff == last_ff) begin
               state_in = S_FIN;
            end
         end
         S_SCAN: begin
            if (rd_data_ff == 8'd0) begin
               wr_en       = 1'b1;
               wr_data     = CLAIMED_COUNT;
               res_addr_in = {PGNUM_W'(idx_ff), {PAGE_SHIFT{1'b0}}};
               state_in    = S_FIN;
            end else if (idx_cw == LAST_PAGE) begin
               res_status_in = ST_NO_PAGE;
               state_in      = S_FIN;
            end else begin
               idx_in = idx_ff + PIDX_W'(1);
            end
         end
         S_FREE_WR: begin
            wr_en    = (rd_data_ff != 8'd0);
            wr_data  = rd_data_ff - 8'd1;
            state_in = S_FIN;
         end
         S_FIN: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         map_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= map_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
      idx_ff        <= idx_in;
      last_ff       <= last_in;
      kern_ff       <= kern_in;
      buf_ff        <= buf_in;
      res_addr_ff   <= res_addr_in;
      res_status_ff <= res_status_in;
   end

   assign ready            = (state_ff == S_IDLE);
   assign res.valid        = (state_ff == S_FIN);
   assign res.page_address = res_addr_ff;
   assign res.status       = res_status_ff;

endmodule

`default_nettype wire

[sv/page_frame_refcount_allocator_unit.sv]
// Top level of the page frame refcount allocator: stream ports, control registers, result register.
// Instantiates pfra_engine; uses pfra_pkg.
//
//   channel | direction | beat contents
//   req_    | in        | tuser[1:0] command, tdata[31:0] address
//   rsp_    | out       | tdata[25:0] page_address, tdata[28:26] status
//   csr_    | in        | csr_index selects register, csr_wdata value, written when csr_we
//
// Free: the page's count is read and written back one lower unless zero; a kernel or
// out-of-range address is refused with the map unchanged, and an unused command changes nothing.
// Allocate: one map read per page scanned, lowest page first, through the single read port
// of the count map. Init: one map write per page up to the end of memory or of the kernel
// area, whichever is higher, capped at PAGE_COUNT; a too-small size writes nothing.
// Reset clears control state only; the count map holds garbage until the first init.
// A result waiting on rsp_tready holds the engine after it finishes, while one more beat
// can still be taken on req_.
`default_nettype none

module page_frame_refcount_allocator_unit
   import pfra_pkg::*;
#(
   parameter int PAGE_COUNT = 16384
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,   // address
   input  wire logic [1:0]  req_tuser,   // command
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata,   // page_address, status, zero pad
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_index,
   input  wire logic [31:0] csr_wdata
);

   pfra_cfg_type cfg_ff, cfg_in;
   pfra_req_type eng_req;
   pfra_res_type eng_res;
   logic         eng_ready;
   logic         out_free;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [31:0]       rsp_data_ff, rsp_data_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_MEMORY_BYTES: cfg_in.memory_bytes = csr_wdata;
            CSR_KERNEL_LIMIT: cfg_in.kernel_limit = csr_wdata[ADDR_W-1:0];
            CSR_FREE_LIMIT:   cfg_in.free_limit   = csr_wdata;
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   assign req_tready      = eng_ready;
   assign eng_req.valid   = req_tvalid & eng_ready;
   assign eng_req.command = req_tuser;
   assign eng_req.address = req_tdata;

   assign out_free = ~rsp_valid_ff | rsp_tready;

   pfra_engine #(
      .PAGE_COUNT (PAGE_COUNT)
   ) u_engine (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .req      (eng_req),
      .ready    (eng_ready),
      .out_free (out_free),
      .res      (eng_res)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_data_in  = rsp_data_ff;
      if (eng_res.valid && out_free) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {3'd0, eng_res.status, eng_res.page_address};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.memory_bytes <= RST_MEMORY_BYTES;
         cfg_ff.kernel_limit <= RST_KERNEL_LIMIT;
         cfg_ff.free_limit   <= RST_FREE_LIMIT;
         rsp_valid_ff        <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire

[tb/page_frame_refcount_allocator_unit_tb.sv]
// Testbench for page_frame_refcount_allocator_unit: init, allocate and free beats are checked
// against a cycle-free model of the per-page count map, under several idling and stall mixes.
// Depends on pfra_pkg and the unit's RTL.
module page_frame_refcount_allocator_unit_tb;
   import pfra_pkg::*;

   localparam int PAGE_COUNT  = 16384;
   localparam int CYCLE_LIMIT = 25_000_000;
   localparam int PLAN = 0;
   localparam int LIVE = 1;
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   typedef struct packed {
      logic [1:0]  command;
      logic [31:0] address;
   } map_cmd_type;

   typedef struct packed {
      logic [ADDR_W-1:0] page_address;
      logic [2:0]        status;
   } map_result_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata  = '0;   // address
   logic [1:0]  req_tuser  = '0;   // command
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;         // page_address, status, zero pad
   logic        csr_we     = 1'b0;
   logic [1:0]  csr_index  = '0;
   logic [31:0] csr_wdata  = '0;

   logic [7:0]   refcount_map [2][PAGE_COUNT];
   bit           map_loaded   [2][PAGE_COUNT];
   pfra_cfg_type map_cfg      [2];

   map_cmd_type    queued_commands [$];
   map_result_type pending_results [$];
   logic [31:0]    held_pages [$];

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int failures  = 0;
   int beats_in  = 0;
   int beats_out = 0;
   int cycles    = 0;
   int status_tally [8];

   page_frame_refcount_allocator_unit #(
      .PAGE_COUNT(PAGE_COUNT)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   function automatic void page_map_step(input int m, input logic [1:0] cmd,
                                         input logic [31:0] addr, output map_result_type res);
      logic [31:0] size;
      logic [31:0] kern_pg;
      logic [31:0] buf_pg;
      logic [31:0] end_pg;
      logic [31:0] pg;
      logic [31:0] full_addr;
      bit          found;
      int          i;
      res    = '0;
      found  = 1'b0;
      pg     = addr >> PAGE_SHIFT;
      case (cmd)
         CMD_INIT: begin
            size = (map_cfg[m].memory_bytes > MEM_CAP) ? MEM_CAP : map_cfg[m].memory_bytes;
            size = size & PAGE_MASK;
            if (size < MEM_MIN) begin
               res.status = ST_TOO_SMALL;
            end else begin
               kern_pg = {6'b0, map_cfg[m].kernel_limit} >> PAGE_SHIFT;
               buf_pg  = (size / 4 - 1) >> PAGE_SHIFT;
               end_pg  = (size - 1) >> PAGE_SHIFT;
               for (i = 0; i < PAGE_COUNT; i++) begin
                  if (i <= kern_pg) begin
                     refcount_map[m][i] = RESERVED_COUNT;
                     map_loaded[m][i]   = 1'b1;
                  end else if (i <= buf_pg) begin
                     refcount_map[m][i] = BUF_COUNT;
                     map_loaded[m][i]   = 1'b1;
                  end else if (i <= end_pg) begin
                     refcount_map[m][i] = 8'd0;
                     map_loaded[m][i]   = 1'b1;
                  end
               end
            end
         end
         CMD_ALLOC: begin
            res.status = ST_NO_PAGE;
            for (i = 0; i < PAGE_COUNT && !found; i++) begin
               if (refcount_map[m][i] == 8'd0) begin
                  refcount_map[m][i] = CLAIMED_COUNT;
                  full_addr          = i << PAGE_SHIFT;
                  res.page_address   = full_addr[ADDR_W-1:0];
                  res.status         = ST_OK;
                  found              = 1'b1;
               end
            end
         end
         CMD_FREE: begin
            if (addr < {6'b0, map_cfg[m].kernel_limit}) begin
               res.status = ST_KERNEL;
            end else if (addr >= map_cfg[m].free_limit || pg >= PAGE_COUNT) begin
               res.status = ST_RANGE;
            end else if (refcount_map[m][pg] != 8'd0) begin
               refcount_map[m][pg] = refcount_map[m][pg] - 8'd1;
            end
         end
         default: begin
         end
      endcase
   endfunction

   // true when the command would read a count that no init has written
   function automatic bit reads_blank_entry(input int m, input logic [1:0] cmd,
                                            input logic [31:0] addr);
      logic [31:0] pg;
      bit          blank;
      bit          done;
      int          i;
      pg    = addr >> PAGE_SHIFT;
      blank = 1'b0;
      done  = 1'b0;
      if (cmd == CMD_ALLOC) begin
         for (i = 0; i < PAGE_COUNT && !done; i++) begin
            if (!map_loaded[m][i]) begin
               blank = 1'b1;
               done  = 1'b1;
            end else if (refcount_map[m][i] == 8'd0) begin
               done = 1'b1;
            end
         end
      end else if (cmd == CMD_FREE && addr >= {6'b0, map_cfg[m].kernel_limit}
                   && addr < map_cfg[m].free_limit && pg < PAGE_COUNT) begin
         blank = !map_loaded[m][pg];
      end
      return blank;
   endfunction

   task automatic queue_command(input logic [1:0] cmd, input logic [31:0] addr);
      map_cmd_type    beat;
      map_result_type res;
      if (reads_blank_entry(PLAN, cmd, addr)) begin
         cmd = CMD_UNUSED;
      end
      page_map_step(PLAN, cmd, addr, res);
      if (cmd == CMD_ALLOC && res.status == ST_OK) begin
         held_pages.push_back({6'b0, res.page_address});
      end
      beat.command = cmd;
      beat.address = addr;
      queued_commands.push_back(beat);
   endtask

   task automatic queue_random_command();
      int pick;
      int slot;
      pick = $urandom_range(99);
      if (pick < 35) begin
         queue_command(CMD_ALLOC, $urandom);
      end else if (pick < 75 && held_pages.size() > 0) begin
         slot = $urandom_range(held_pages.size() - 1);
         queue_command(CMD_FREE, held_pages[slot] | $urandom_range(12'hFFF));
         if ($urandom_range(3) != 0) begin
            held_pages.delete(slot);
         end
      end else if (pick < 85) begin
         queue_command(CMD_FREE, $urandom_range(32'h0400_0000));
      end else if (pick < 92) begin
         queue_command(CMD_FREE, $urandom);
      end else if (pick < 96) begin
         queue_command(CMD_UNUSED, $urandom);
      end else begin
         queue_command(CMD_INIT, $urandom);
      end
   endtask

   task automatic drain();
      do @(negedge clock);
      while (queued_commands.size() != 0 || req_tvalid || pending_results.size() != 0);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_reg(input logic [1:0] reg_index, input logic [31:0] value);
      int m;
      drain();
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= reg_index;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      for (m = PLAN; m <= LIVE; m++) begin
         case (reg_index)
            CSR_MEMORY_BYTES: map_cfg[m].memory_bytes = value;
            CSR_KERNEL_LIMIT: map_cfg[m].kernel_limit = value[ADDR_W-1:0];
            CSR_FREE_LIMIT:   map_cfg[m].free_limit   = value;
            default: begin
            end
         endcase
      end
      @(negedge clock);
   endtask

   task automatic random_small_settings();
      write_reg(CSR_MEMORY_BYTES, MEM_MIN + $urandom_range(32'h0040_0000));
      write_reg(CSR_KERNEL_LIMIT, $urandom_range(32'h0020_0000));
      write_reg(CSR_FREE_LIMIT, $urandom_range(32'h0030_0000, 32'h0090_0000));
   endtask

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      for (cycles = 0; cycles < CYCLE_LIMIT; cycles++) begin
         @(posedge clock);
      end
      $display("simulation failed");
      $finish;
   end

   always @(posedge clock) begin : drive_req
      map_cmd_type beat;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (queued_commands.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            beat = queued_commands.pop_front();
            req_tvalid <= 1'b1;
            req_tdata  <= beat.address;
            req_tuser  <= beat.command;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin : watch_beats
      map_result_type want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            beats_out++;
            if (pending_results.size() == 0) begin
               $error("result beat with nothing expected: tdata %h", rsp_tdata);
               failures++;
            end else begin
               want = pending_results.pop_front();
               status_tally[want.status]++;
               if (rsp_tdata[ADDR_W-1:0] !== want.page_address) begin
                  $error("page_address: expected %h, got %h",
                         want.page_address, rsp_tdata[ADDR_W-1:0]);
                  failures++;
               end
               if (rsp_tdata[ADDR_W+2:ADDR_W] !== want.status) begin
                  $error("status: expected %0d, got %0d",
                         want.status, rsp_tdata[ADDR_W+2:ADDR_W]);
                  failures++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            beats_in++;
            page_map_step(LIVE, req_tuser, req_tdata, want);
            pending_results.push_back(want);
         end
      end
   end

   initial begin
      int m;
      int i;
      for (m = PLAN; m <= LIVE; m++) begin
         map_cfg[m] = {RST_MEMORY_BYTES, RST_KERNEL_LIMIT, RST_FREE_LIMIT};
         for (i = 0; i < PAGE_COUNT; i++) begin
            refcount_map[m][i] = 8'd0;
            map_loaded[m][i]   = 1'b0;
         end
      end
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset settings: 60 MB, kernel below 1 MB, frees up to 60 MB
      queue_command(CMD_UNUSED, 32'hFFFF_FFFF);
      queue_command(CMD_INIT,   32'h0000_0000);
      queue_command(CMD_ALLOC,  32'hFFFF_FFFF);
      queue_command(CMD_ALLOC,  32'h0000_0000);
      queue_command(CMD_FREE,   32'h00F0_0000);
      queue_command(CMD_FREE,   32'h00F0_0FFF);
      queue_command(CMD_FREE,   32'h0000_0000);
      queue_command(CMD_FREE,   32'h000F_FFFF);
      queue_command(CMD_FREE,   32'h0010_0000);
      queue_command(CMD_FREE,   32'h0020_0000);
      queue_command(CMD_FREE,   32'h03BF_FFFF);
      queue_command(CMD_FREE,   32'h03C0_0000);
      queue_command(CMD_FREE,   32'hFFFF_FFFF);
      queue_command(CMD_ALLOC,  32'h0000_0000);
      queue_command(CMD_UNUSED, 32'h0000_0000);

      write_reg(CSR_MEMORY_BYTES, 32'h0000_0000);
      queue_command(CMD_INIT, 32'h0000_0000);
      write_reg(CSR_MEMORY_BYTES, 32'h003F_FFFF);
      queue_command(CMD_INIT, 32'h0000_0000);
      write_reg(CSR_MEMORY_BYTES, 32'h0040_0FFF);
      queue_command(CMD_INIT, 32'h0000_0000);
      queue_command(CMD_ALLOC, 32'h0000_0000);

      // kernel covers the whole map: every page reserved
      write_reg(CSR_KERNEL_LIMIT, 32'hFFFF_FFFF);
      write_reg(CSR_FREE_LIMIT, 32'hFFFF_FFFF);
      write_reg(CSR_MEMORY_BYTES, 32'hFFFF_FFFF);
      queue_command(CMD_INIT,  32'h0000_0000);
      queue_command(CMD_ALLOC, 32'h0000_0000);
      queue_command(CMD_FREE,  32'h03FF_FFFF);
      queue_command(CMD_FREE,  32'h03FF_FFFE);
      queue_command(CMD_FREE,  32'h0400_0000);

      write_reg(CSR_KERNEL_LIMIT, 32'h0000_0000);
      write_reg(CSR_FREE_LIMIT, 32'h0000_0000);
      queue_command(CMD_FREE, 32'h0000_0000);
      queue_command(CMD_FREE, 32'h8000_1234);

      random_small_settings();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      queue_command(CMD_INIT, $urandom);
      repeat (15) queue_random_command();

      random_small_settings();
      send_idle_pct  = 86;
      recv_stall_pct = 0;
      queue_command(CMD_INIT, $urandom);
      repeat (8) queue_random_command();
      drain();
      repeat (8) queue_random_command();

      // step page zero down from reserved, then allocate
      write_reg(CSR_KERNEL_LIMIT, 32'h0000_0000);
      write_reg(CSR_MEMORY_BYTES, MEM_MIN + $urandom_range(12'hFFF));
      write_reg(CSR_FREE_LIMIT, $urandom_range(32'h0100_0000, 32'hFFFF_FFFF));
      send_idle_pct  = 0;
      recv_stall_pct = 86;
      queue_command(CMD_INIT, $urandom);
      repeat (8) queue_command(CMD_FREE, $urandom_range(12'hFFF));
      queue_command(CMD_ALLOC, $urandom);
      repeat (8) queue_random_command();

      write_reg(CSR_MEMORY_BYTES, $urandom);
      write_reg(CSR_KERNEL_LIMIT, $urandom_range(32'h0040_0000));
      write_reg(CSR_FREE_LIMIT, $urandom);
      send_idle_pct  = 38;
      recv_stall_pct = 38;
      queue_command(CMD_INIT, $urandom);
      repeat (15) queue_random_command();

      drain();
      repeat (64) @(negedge clock);
      $display("%0d command beats, %0d result beats in %0d cycles across four idling mixes",
               beats_in, beats_out, cycles);
      $display("statuses: ok %0d, no page %0d, kernel %0d, out of range %0d, too small %0d",
               status_tally[ST_OK], status_tally[ST_NO_PAGE], status_tally[ST_KERNEL],
               status_tally[ST_RANGE], status_tally[ST_TOO_SMALL]);
      if (failures == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

[page_frame_refcount_allocator_unit.f]
sv/pfra_pkg.sv
sv/pfra_engine.sv
sv/page_frame_refcount_allocator_unit.sv
tb/page_frame_refcount_allocator_unit_tb.sv
